// ----- src/m3sh_pkg.sv -----
// m3sh_pkg: types, constants and helpers of the streaming 32-bit hash.
// Used by m3sh_front, m3sh_queue, m3sh_back and murmur3_32_stream_hash.
// No dependencies.
`timescale 1ns / 1ps

package m3sh_pkg;

	localparam logic [31:0] MIX_C1 = 32'hCC9E2D51;
	localparam logic [31:0] MIX_C2 = 32'h1B873593;
	localparam logic [31:0] MIX_N  = 32'hE6546B64;
	localparam logic [31:0] FIN_C1 = 32'h85EBCA6B;
	localparam logic [31:0] FIN_C2 = 32'hC2B2AE35;

	localparam logic [2:0] CNT_FULL = 3'd4;

	typedef enum logic [1:0] {
		KIND_EMPTY = 2'd0,
		KIND_PART  = 2'd1,
		KIND_FULL  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  cnt;
		logic        last;
		kind_t       kind;
	} item_t;

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] prod;
		prod = {32'd0, a} * {32'd0, b};
		return prod[31:0];
	endfunction

endpackage

// ----- src/m3sh_front.sv -----
// m3sh_front: classifies an incoming word, saturates the byte count and masks
// unused bytes. Depends on m3sh_pkg.
`timescale 1ns / 1ps

module m3sh_front (
	input  logic [31:0]    data_word,
	input  logic [2:0]     byte_count,
	input  logic           last_word,
	output m3sh_pkg::item_t item
);
	import m3sh_pkg::*;

	logic [2:0] cnt_sat;

	always_comb begin
		cnt_sat = (byte_count > CNT_FULL) ? CNT_FULL : byte_count;
		item.cnt  = cnt_sat;
		item.last = last_word;
		case (cnt_sat)
			3'd0: begin
				item.data = 32'd0;
				item.kind = KIND_EMPTY;
			end
			3'd1: begin
				item.data = {24'd0, data_word[7:0]};
				item.kind = KIND_PART;
			end
			3'd2: begin
				item.data = {16'd0, data_word[15:0]};
				item.kind = KIND_PART;
			end
			3'd3: begin
				item.data = {8'd0, data_word[23:0]};
				item.kind = KIND_PART;
			end
			default: begin
				item.data = data_word;
				item.kind = KIND_FULL;
			end
		endcase
	end

endmodule

// ----- src/m3sh_queue.sv -----
// m3sh_queue: short register queue between the front and the back.
// Depends on m3sh_pkg.
`timescale 1ns / 1ps

module m3sh_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  m3sh_pkg::item_t wr_item,
	output logic            full,
	input  logic            rd_en,
	output m3sh_pkg::item_t rd_item,
	output logic            empty
);
	import m3sh_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_MAX  = CW'(DEPTH);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full    = (count_q == CNT_MAX);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/m3sh_back.sv -----
// m3sh_back: sequencer for the block mix, tail mix and finalisation, with
// the result register. Depends on m3sh_pkg.
`timescale 1ns / 1ps

module m3sh_back (
	input  logic            clk,
	input  logic            arst_n,
	input  m3sh_pkg::item_t item,
	input  logic            q_empty,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output logic [31:0]     hash_value
);
	import m3sh_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL1 = 7'b0000010,
		ST_MUL2 = 7'b0000100,
		ST_MIX  = 7'b0001000,
		ST_FIN1 = 7'b0010000,
		ST_FIN2 = 7'b0100000,
		ST_FIN3 = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [31:0] h_q, total_q, work_q, out_q;
	logic [2:0]  cnt_q;
	logic        last_q, full_q, out_valid_q;
	logic [31:0] hx, hr, fx, f2x, f3x;
	logic        out_free;

	assign q_pop      = (state_q == ST_IDLE) && !q_empty;
	assign empty      = !out_valid_q;
	assign hash_value = out_q;
	assign out_free   = !out_valid_q || pop;

	always_comb begin
		hx  = h_q ^ work_q;
		hr  = {hx[18:0], hx[31:19]};
		fx  = h_q ^ total_q;
		f2x = work_q ^ {13'd0, work_q[31:13]};
		f3x = work_q ^ {16'd0, work_q[31:16]};
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				work_q <= item.data;
				cnt_q  <= item.cnt;
				last_q <= item.last;
				full_q <= (item.kind == KIND_FULL);
			end
			ST_MUL1: work_q <= mul32(work_q, MIX_C1);
			ST_MUL2: work_q <= mul32({work_q[16:0], work_q[31:17]}, MIX_C2);
			ST_FIN1: work_q <= mul32(fx ^ {16'd0, fx[31:16]}, FIN_C1);
			ST_FIN2: work_q <= mul32(f2x, FIN_C2);
			default: ;
		endcase
		if (state_q == ST_FIN3 && out_free) begin
			out_q <= f3x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			h_q         <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN3 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (item.kind != KIND_EMPTY) begin
							state_q <= ST_MUL1;
						end else if (item.last) begin
							state_q <= ST_FIN1;
						end
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MIX;
				ST_MIX: begin
					h_q     <= full_q ? (hr + {hr[29:0], 2'b00} + MIX_N) : hx;
					total_q <= total_q + {29'd0, cnt_q};
					state_q <= last_q ? ST_FIN1 : ST_IDLE;
				end
				ST_FIN1: state_q <= ST_FIN2;
				ST_FIN2: state_q <= ST_FIN3;
				ST_FIN3: begin
					if (out_free) begin
						h_q         <= '0;
						total_q     <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- src/murmur3_32_stream_hash.sv -----
// murmur3_32_stream_hash: top level of the streaming 32-bit hash, seed zero.
// Depends on m3sh_pkg, m3sh_front, m3sh_queue and m3sh_back.
// Words go in through push/full and hashes come out through empty/pop. The
// back sequencer takes a word of one to four bytes through fetch, two k
// multiplies and the h update, and a zero-byte word through the fetch alone; a
// last word then passes the finalisation steps (two multiplies and the final
// xor-shift, which waits for a free result register) before its hash appears.
// The input queue (QUEUE_DEPTH words) keeps accepting while a hash waits to be
// popped.
`timescale 1ns / 1ps

module murmur3_32_stream_hash #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last_word,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] hash_value
);
	import m3sh_pkg::*;

	item_t in_item, q_item;
	logic  q_empty, q_pop;

	m3sh_front u_front (
		.data_word  (data_word),
		.byte_count (byte_count),
		.last_word  (last_word),
		.item       (in_item)
	);

	m3sh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_item (in_item),
		.full    (full),
		.rd_en   (q_pop),
		.rd_item (q_item),
		.empty   (q_empty)
	);

	m3sh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (q_item),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.hash_value (hash_value)
	);

endmodule
